/* rtl/core/clex_pkg.sv */
`default_nettype none

package clex_pkg;

  typedef enum logic [4:0] {
    K_INT  = 5'd0,
    K_PLUS = 5'd1,
    K_MINUS = 5'd2,
    K_MUL  = 5'd3,
    K_DIV  = 5'd4,
    K_MOD  = 5'd5,
    K_EQ   = 5'd6,
    K_NE   = 5'd7,
    K_LT   = 5'd8,
    K_LE   = 5'd9,
    K_GT   = 5'd10,
    K_GE   = 5'd11,
    K_SHL  = 5'd12,
    K_SHR  = 5'd13,
    K_LNOT = 5'd14,
    K_AND  = 5'd15,
    K_LAND = 5'd16,
    K_OR   = 5'd17,
    K_LOR  = 5'd18,
    K_XOR  = 5'd19,
    K_NOT  = 5'd20,
    K_LP   = 5'd21,
    K_RP   = 5'd22,
    K_END  = 5'd23,
    K_ERR  = 5'd24
  } kind_t;

  typedef enum logic [3:0] {
    M_START = 4'd0,
    M_ZERO  = 4'd1,
    M_ZX    = 4'd2,
    M_HEX   = 4'd3,
    M_OCT   = 4'd4,
    M_DEC   = 4'd5,
    M_EQ    = 4'd6,
    M_BANG  = 4'd7,
    M_LT    = 4'd8,
    M_GT    = 4'd9,
    M_AMP   = 4'd10,
    M_PIPE  = 4'd11,
    M_DROP  = 4'd12
  } mode_t;

  localparam int AccW = 64;

  // Outcome of one character: up to two tokens, the second never a literal.
  typedef struct packed {
    logic [1:0]      cnt;
    kind_t           kind0;
    logic [AccW-1:0] val0;
    kind_t           kind1;
    mode_t           mode;
    logic [AccW-1:0] acc;
  } step_res_t;

  typedef struct packed {
    kind_t           kind;
    logic [AccW-1:0] value;
    logic            last;
  } tok_t;

endpackage

`default_nettype wire

/* rtl/core/clex_step.sv */
`default_nettype none

module clex_step (
  input  clex_pkg::mode_t     mode,
  input  logic [63:0]         acc,
  input  logic [7:0]          c,
  output clex_pkg::step_res_t res
);
  import clex_pkg::*;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChLp    = 8'h28;
  localparam logic [7:0] ChRp    = 8'h29;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch1     = 8'h31;
  localparam logic [7:0] Ch7     = 8'h37;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChLoA   = 8'h61;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] ChLoX   = 8'h78;
  localparam logic [7:0] ChPipe  = 8'h7C;
  localparam logic [7:0] ChTilde = 8'h7E;

  logic        is_dig, is_oct, is_alpha_hex, is_hex, is_ws;
  logic [3:0]  hv;
  logic [63:0] dval, hex_acc, oct_acc, dec_acc;

  // begin-of-token path
  logic        b_emit;
  kind_t       b_kind;
  mode_t       b_mode;
  logic [63:0] b_acc_in, b_acc;

  // prefix token when the character closes a pending token
  logic        use_begin, pre_v;
  kind_t       pre_k;
  logic [63:0] pre_val;

  // direct outcome
  logic [1:0]  d_cnt;
  kind_t       d_k0, d_k1;
  mode_t       d_mode;
  logic [63:0] d_acc;

  assign is_dig = (c >= Ch0) && (c <= Ch9);
  assign is_oct = (c >= Ch0) && (c <= Ch7);
  assign is_alpha_hex = ((c >= ChLoA) && (c <= ChLoF)) || ((c >= ChUpA) && (c <= ChUpF));
  assign is_hex = is_dig || is_alpha_hex;
  assign is_ws  = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
  // Letters a-f and A-F share their low nibble; add nine to map 1..6 to 10..15.
  assign hv     = is_dig ? c[3:0] : (c[3:0] + 4'd9);
  assign dval   = {60'd0, hv};

  assign hex_acc = {acc[59:0], 4'b0} + dval;
  assign oct_acc = {acc[60:0], 3'b0} + dval;
  assign dec_acc = {acc[60:0], 3'b0} + {acc[62:0], 1'b0} + dval;

  always_comb begin
    b_emit = 1'b0;
    b_kind = K_END;
    b_mode = M_START;
    b_acc  = b_acc_in;
    if (c == ChNul) begin
      b_emit = 1'b1;
      b_kind = K_END;
      b_acc  = '0;
    end else if (c == Ch0) begin
      b_mode = M_ZERO;
      b_acc  = '0;
    end else if ((c >= Ch1) && (c <= Ch9)) begin
      b_mode = M_DEC;
      b_acc  = dval;
    end else if (is_ws) begin
      b_mode = M_START;
    end else begin
      unique case (c)
        ChPlus:  begin b_emit = 1'b1; b_kind = K_PLUS;  end
        ChMinus: begin b_emit = 1'b1; b_kind = K_MINUS; end
        ChStar:  begin b_emit = 1'b1; b_kind = K_MUL;   end
        ChSlash: begin b_emit = 1'b1; b_kind = K_DIV;   end
        ChPct:   begin b_emit = 1'b1; b_kind = K_MOD;   end
        ChCaret: begin b_emit = 1'b1; b_kind = K_XOR;   end
        ChTilde: begin b_emit = 1'b1; b_kind = K_NOT;   end
        ChLp:    begin b_emit = 1'b1; b_kind = K_LP;    end
        ChRp:    begin b_emit = 1'b1; b_kind = K_RP;    end
        ChEq:    b_mode = M_EQ;
        ChBang:  b_mode = M_BANG;
        ChLt:    b_mode = M_LT;
        ChGt:    b_mode = M_GT;
        ChAmp:   b_mode = M_AMP;
        ChPipe:  b_mode = M_PIPE;
        default: begin
          b_emit = 1'b1;
          b_kind = K_ERR;
          b_mode = M_DROP;
          b_acc  = '0;
        end
      endcase
    end
  end

  always_comb begin
    use_begin = 1'b0;
    pre_v     = 1'b0;
    pre_k     = K_INT;
    pre_val   = '0;
    b_acc_in  = acc;
    d_cnt     = 2'd0;
    d_k0      = K_ERR;
    d_k1      = K_END;
    d_mode    = mode;
    d_acc     = acc;
    // An error on the zero byte also closes the expression in the same step.
    if (c == ChNul) begin
      d_cnt  = 2'd2;
      d_mode = M_START;
    end else begin
      d_cnt  = 2'd1;
      d_mode = M_DROP;
    end
    d_acc = '0;

    unique case (mode)
      M_ZERO: begin
        if ((c == ChLoX) || (c == ChUpX)) begin
          d_cnt = 2'd0; d_mode = M_ZX; d_acc = acc;
        end else if (is_oct) begin
          d_cnt = 2'd0; d_mode = M_OCT; d_acc = dval;
        end else if (!is_dig) begin
          use_begin = 1'b1; pre_v = 1'b1; pre_val = acc; b_acc_in = '0;
        end
      end
      M_ZX: begin
        if (is_hex) begin
          d_cnt = 2'd0; d_mode = M_HEX; d_acc = dval;
        end
      end
      M_HEX: begin
        if (is_hex) begin
          d_cnt = 2'd0; d_mode = M_HEX; d_acc = hex_acc;
        end else begin
          use_begin = 1'b1; pre_v = 1'b1; pre_val = acc; b_acc_in = '0;
        end
      end
      M_OCT: begin
        if (is_oct) begin
          d_cnt = 2'd0; d_mode = M_OCT; d_acc = oct_acc;
        end else if (!is_dig) begin
          use_begin = 1'b1; pre_v = 1'b1; pre_val = acc; b_acc_in = '0;
        end
      end
      M_DEC: begin
        if (is_dig) begin
          d_cnt = 2'd0; d_mode = M_DEC; d_acc = dec_acc;
        end else begin
          use_begin = 1'b1; pre_v = 1'b1; pre_val = acc; b_acc_in = '0;
        end
      end
      M_EQ: begin
        if (c == ChEq) begin
          d_cnt = 2'd1; d_k0 = K_EQ; d_mode = M_START; d_acc = acc;
        end
      end
      M_BANG: begin
        if (c == ChEq) begin
          d_cnt = 2'd1; d_k0 = K_NE; d_mode = M_START; d_acc = acc;
        end else begin
          use_begin = 1'b1; pre_v = 1'b1; pre_k = K_LNOT;
        end
      end
      M_LT: begin
        if (c == ChEq) begin
          d_cnt = 2'd1; d_k0 = K_LE; d_mode = M_START; d_acc = acc;
        end else if (c == ChLt) begin
          d_cnt = 2'd1; d_k0 = K_SHL; d_mode = M_START; d_acc = acc;
        end else begin
          use_begin = 1'b1; pre_v = 1'b1; pre_k = K_LT;
        end
      end
      M_GT: begin
        if (c == ChEq) begin
          d_cnt = 2'd1; d_k0 = K_GE; d_mode = M_START; d_acc = acc;
        end else if (c == ChGt) begin
          d_cnt = 2'd1; d_k0 = K_SHR; d_mode = M_START; d_acc = acc;
        end else begin
          use_begin = 1'b1; pre_v = 1'b1; pre_k = K_GT;
        end
      end
      M_AMP: begin
        if (c == ChAmp) begin
          d_cnt = 2'd1; d_k0 = K_LAND; d_mode = M_START; d_acc = acc;
        end else begin
          use_begin = 1'b1; pre_v = 1'b1; pre_k = K_AND;
        end
      end
      M_PIPE: begin
        if (c == ChPipe) begin
          d_cnt = 2'd1; d_k0 = K_LOR; d_mode = M_START; d_acc = acc;
        end else begin
          use_begin = 1'b1; pre_v = 1'b1; pre_k = K_OR;
        end
      end
      M_DROP: begin
        if (c == ChNul) begin
          d_cnt = 2'd1; d_k0 = K_END; d_mode = M_START; d_acc = '0;
        end else begin
          d_cnt = 2'd0; d_mode = M_DROP; d_acc = acc;
        end
      end
      default: use_begin = 1'b1;
    endcase
  end

  always_comb begin
    res.cnt   = d_cnt;
    res.kind0 = d_k0;
    res.val0  = '0;
    res.kind1 = d_k1;
    res.mode  = d_mode;
    res.acc   = d_acc;
    if (use_begin) begin
      res.mode = b_mode;
      res.acc  = b_acc;
      if (pre_v) begin
        res.kind0 = pre_k;
        res.val0  = pre_val;
        res.kind1 = b_kind;
        res.cnt   = b_emit ? 2'd2 : 2'd1;
      end else begin
        res.kind0 = b_kind;
        res.cnt   = b_emit ? 2'd1 : 2'd0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/c_expression_lexer.sv */
`default_nettype none

// Channel  Dir  tdata                                       tuser  tlast
// s_axis   in   [7:0] char_code                             -      -
// m_axis   out  [4:0] token_kind, [68:5] token_value, pad   -      last_of_item
//
// One character is taken per cycle; the lexer mode and the 64-bit accumulator
// update in the same cycle, so a character can follow in the next cycle.
// Tokens go into a four-word output queue and leave one word per cycle while m_tready is high.
// s_tready is high while the queue has room for two words, so the input side
// stalls only when a slow consumer lets the queue fill up.
// Reset (rst, synchronous) empties the queue and returns to start of token.
module c_expression_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [4:0] token_kind, [68:5] token_value, [71:69] zero
  output logic        m_tlast
);
  import clex_pkg::*;

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  mode_t           mode;
  logic [AccW-1:0] acc;
  step_res_t       res;

  tok_t            queue [QDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] cnt, cnt_next;
  logic            s_fire, m_fire;
  logic [CntW-1:0] push_n;
  tok_t            head;

  clex_step u_step (
    .mode (mode),
    .acc  (acc),
    .c    (s_tdata),
    .res  (res)
  );

  assign s_tready = (cnt <= CntW'(QDepth - 2));
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = (cnt != '0);
  assign m_fire   = m_tvalid && m_tready;
  assign push_n   = s_fire ? CntW'(res.cnt) : '0;
  assign cnt_next = cnt + push_n - CntW'(m_fire);

  assign head    = queue[rd_ptr];
  assign m_tdata = {3'b000, head.value, head.kind};
  assign m_tlast = head.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_START;
      acc    <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (s_fire) begin
        mode   <= res.mode;
        acc    <= res.acc;
        wr_ptr <= wr_ptr + PtrW'(res.cnt);
      end
      if (m_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt_next;
    end
  end

  // The second word of a character is never a literal, so its value is zero.
  always_ff @(posedge clk) begin
    if (s_fire && (res.cnt != 2'd0)) begin
      queue[wr_ptr] <= '{kind: res.kind0, value: res.val0, last: (res.cnt == 2'd1)};
    end
    if (s_fire && (res.cnt == 2'd2)) begin
      queue[wr_ptr + 1'b1] <= '{kind: res.kind1, value: '0, last: 1'b1};
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CntW'(QDepth))
    else $error("output queue count out of range");

  a_nul_closes: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (s_tdata == 8'h00)) |=> (mode == M_START) && (acc == '0))
    else $error("zero byte did not return the lexer to start of token");

  a_nul_emits: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (s_tdata == 8'h00)) |-> (res.cnt != 2'd0))
    else $error("zero byte produced no end word");

  a_drop_silent: assert property (@(posedge clk) disable iff (rst)
    (s_fire && (mode == M_DROP) && (s_tdata != 8'h00)) |-> (res.cnt == 2'd0))
    else $error("word produced while dropping after an error");

  a_cnt_track: assert property (@(posedge clk) disable iff (rst)
    !s_fire && !m_fire |=> $stable(cnt))
    else $error("queue count changed without a transfer");
`endif

endmodule

`default_nettype wire

/* dv/c_expression_lexer_chk.sv */
module c_expression_lexer_chk (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic        m_tlast,
  output int          mismatches,
  output int          outstanding,
  output int          tokens_checked,
  output int          kinds_seen
);
  import clex_pkg::*;

  mode_t       lex_mode;
  logic [63:0] acc;
  tok_t        expected_tokens[$];
  kind_t       step_kind [2];
  logic [63:0] step_value [2];
  int          step_n;
  logic [24:0] seen = '0;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  task automatic emit(input kind_t k, input logic [63:0] v);
    step_kind[step_n] = k;
    step_value[step_n] = v;
    step_n++;
  endtask

  task automatic go_end();
    emit(K_END, 64'd0);
    lex_mode = M_START;
    acc = '0;
  endtask

  // A zero byte that causes an error also ends the expression in the same step.
  task automatic flag_error(input logic [7:0] c);
    emit(K_ERR, 64'd0);
    acc = '0;
    if (c == 8'h00) go_end();
    else lex_mode = M_DROP;
  endtask

  task automatic start_token(input logic [7:0] c);
    lex_mode = M_START;
    if (c == 8'h00) begin
      go_end();
    end else if (c == "0") begin
      lex_mode = M_ZERO;
      acc = '0;
    end else if (c >= "1" && c <= "9") begin
      lex_mode = M_DEC;
      acc = {56'd0, c - "0"};
    end else begin
      case (c)
        "+": emit(K_PLUS, 64'd0);
        "-": emit(K_MINUS, 64'd0);
        "*": emit(K_MUL, 64'd0);
        "/": emit(K_DIV, 64'd0);
        "%": emit(K_MOD, 64'd0);
        "^": emit(K_XOR, 64'd0);
        "~": emit(K_NOT, 64'd0);
        "(": emit(K_LP, 64'd0);
        ")": emit(K_RP, 64'd0);
        "=": lex_mode = M_EQ;
        "!": lex_mode = M_BANG;
        "<": lex_mode = M_LT;
        ">": lex_mode = M_GT;
        "&": lex_mode = M_AMP;
        "|": lex_mode = M_PIPE;
        8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, " ": ;
        default: flag_error(c);
      endcase
    end
  endtask

  task automatic close_num(input logic [7:0] c);
    emit(K_INT, acc);
    acc = '0;
    start_token(c);
  endtask

  // Advances the lexer by one character and queues the tokens it produces.
  task automatic lex_char(input logic [7:0] c);
    int   hv;
    logic is_oct;
    logic is_dig;
    tok_t tok;
    hv = hex_digit(c);
    is_oct = (c >= "0" && c <= "7");
    is_dig = (c >= "0" && c <= "9");
    step_n = 0;
    case (lex_mode)
      M_ZERO: begin
        if (c == "x" || c == "X") lex_mode = M_ZX;
        else if (is_oct) begin
          lex_mode = M_OCT;
          acc = {61'd0, c[2:0]};
        end else if (is_dig) flag_error(c);
        else close_num(c);
      end
      M_ZX: begin
        if (hv >= 0) begin
          lex_mode = M_HEX;
          acc = {60'd0, hv[3:0]};
        end else flag_error(c);
      end
      M_HEX: begin
        if (hv >= 0) acc = {acc[59:0], hv[3:0]};
        else close_num(c);
      end
      M_OCT: begin
        if (is_oct) acc = {acc[60:0], c[2:0]};
        else if (is_dig) flag_error(c);
        else close_num(c);
      end
      M_DEC: begin
        if (is_dig) acc = acc * 64'd10 + {56'd0, c - "0"};
        else close_num(c);
      end
      M_EQ: begin
        if (c == "=") begin
          emit(K_EQ, 64'd0);
          lex_mode = M_START;
        end else flag_error(c);
      end
      M_BANG: begin
        if (c == "=") begin
          emit(K_NE, 64'd0);
          lex_mode = M_START;
        end else begin
          emit(K_LNOT, 64'd0);
          start_token(c);
        end
      end
      M_LT: begin
        if (c == "=") begin
          emit(K_LE, 64'd0);
          lex_mode = M_START;
        end else if (c == "<") begin
          emit(K_SHL, 64'd0);
          lex_mode = M_START;
        end else begin
          emit(K_LT, 64'd0);
          start_token(c);
        end
      end
      M_GT: begin
        if (c == "=") begin
          emit(K_GE, 64'd0);
          lex_mode = M_START;
        end else if (c == ">") begin
          emit(K_SHR, 64'd0);
          lex_mode = M_START;
        end else begin
          emit(K_GT, 64'd0);
          start_token(c);
        end
      end
      M_AMP: begin
        if (c == "&") begin
          emit(K_LAND, 64'd0);
          lex_mode = M_START;
        end else begin
          emit(K_AND, 64'd0);
          start_token(c);
        end
      end
      M_PIPE: begin
        if (c == "|") begin
          emit(K_LOR, 64'd0);
          lex_mode = M_START;
        end else begin
          emit(K_OR, 64'd0);
          start_token(c);
        end
      end
      M_DROP: begin
        if (c == 8'h00) go_end();
      end
      default: start_token(c);
    endcase
    for (int i = 0; i < step_n; i++) begin
      tok.kind = step_kind[i];
      tok.value = step_value[i];
      tok.last = (i == step_n - 1);
      expected_tokens.insert(expected_tokens.size(), tok);
    end
  endtask

  always @(posedge clk) begin
    logic [4:0]  got_kind;
    logic [63:0] got_value;
    tok_t        want;
    if (rst) begin
      lex_mode = M_START;
      acc = '0;
      expected_tokens.delete();
    end else begin
      // Predict first so a word could in principle leave in its own cycle.
      if (s_tvalid && s_tready) lex_char(s_tdata);
      if (m_tvalid && m_tready) begin
        got_kind = m_tdata[4:0];
        got_value = m_tdata[68:5];
        if (expected_tokens.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected token: kind %0d value 0x%h last %0b",
                     got_kind, got_value, m_tlast);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          tokens_checked++;
          if (got_kind <= 5'd24) seen[got_kind] = 1'b1;
          if (got_kind !== want.kind || got_value !== want.value || m_tlast !== want.last)
          begin
            if (mismatches < 10)
              $display("Token %0d wrong: want kind %0d value 0x%h last %0b,",
                       tokens_checked, want.kind, want.value, want.last,
                       " got kind %0d value 0x%h last %0b",
                       got_kind, got_value, m_tlast);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_tokens.size();
    kinds_seen = $countones(seen);
  end

endmodule

/* dv/tb_c_expression_lexer.sv */
module tb_c_expression_lexer;

  localparam int CharTarget = 500;
  localparam int CycleLimit = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic        m_tlast;
  logic        calm = 1'b0;

  int mismatches;
  int outstanding;
  int tokens_checked;
  int kinds_seen;
  int cycle_count = 0;
  int chars_sent = 0;
  int total_chars = 0;
  int exprs_sent = 0;
  int faulty_exprs = 0;

  logic [7:0] text_q[$];
  string op_list[22] = '{"+", "-", "*", "/", "%", "==", "!=", "<", "<=", ">", ">=",
                         "<<", ">>", "!", "&", "&&", "|", "||", "^", "~", "(", ")"};
  string hex_chars = "0123456789abcdefABCDEF";

  c_expression_lexer u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  c_expression_lexer_chk u_chk (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .mismatches     (mismatches),
    .outstanding    (outstanding),
    .tokens_checked (tokens_checked),
    .kinds_seen     (kinds_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Run timed out after %0d cycles with %0d tokens pending.",
               cycle_count, outstanding);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic push_char(input logic [7:0] c);
    while (!calm && $urandom_range(0, 99) < 14) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    total_chars++;
    @(negedge clk);
  endtask

  task automatic send_text(input string t);
    for (int i = 0; i < t.len(); i++) push_char(t[i]);
  endtask

  task automatic append_byte(input logic [7:0] b);
    text_q.insert(text_q.size(), b);
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) append_byte(t[i]);
  endtask

  task automatic add_space();
    int r;
    r = $urandom_range(0, 9);
    if (r >= 8) append_byte(8'($urandom_range(9, 13)));
    else if (r >= 3) append_byte(" ");
  endtask

  // Mostly short literals; now and then a long one that wraps the accumulator.
  task automatic add_number();
    int len;
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        append_byte(8'($urandom_range(49, 57)));
        for (int i = 1; i < len; i++) append_byte(8'($urandom_range(48, 57)));
      end
      4, 5: begin
        add_text($urandom_range(0, 1) ? "0x" : "0X");
        for (int i = 0; i < len; i++) append_byte(hex_chars[$urandom_range(0, 21)]);
      end
      6, 7: begin
        add_text("0");
        for (int i = 0; i < len; i++) append_byte(8'($urandom_range(48, 55)));
      end
      8: add_text("0");
      default: begin
        case ($urandom_range(0, 3))
          0: add_text("18446744073709551615");
          1: add_text("0xFFFFFFFFFFFFFFFF");
          2: add_text("0x10000000000000000");
          default: add_text("01777777777777777777777");
        endcase
      end
    endcase
  endtask

  task automatic add_fault();
    case ($urandom_range(0, 4))
      0: append_byte(8'($urandom_range(1, 255)));
      1: add_text($urandom_range(0, 1) ? "0xg" : "0x)");
      2: begin
        add_text("0");
        append_byte(8'($urandom_range(56, 57)));
      end
      3: begin
        add_text("017");
        append_byte(8'($urandom_range(56, 57)));
      end
      default: add_text($urandom_range(0, 1) ? "=a" : "= ");
    endcase
  endtask

  // One expression closed by a zero byte; at most one fault, after which the
  // block drops the rest, so those characters are not counted as useful.
  task automatic build_expr(output int useful, output bit faulty);
    int n_tok;
    int r;
    text_q.delete();
    faulty = 1'b0;
    useful = 0;
    n_tok = $urandom_range(1, 8);
    for (int i = 0; i < n_tok; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) add_number();
      else if (r < 93 || faulty) add_text(op_list[$urandom_range(0, 21)]);
      else begin
        add_fault();
        faulty = 1'b1;
        useful = text_q.size();
      end
      add_space();
    end
    if (!faulty) useful = text_q.size() + 1;
    append_byte(8'h00);
  endtask

  initial begin
    int useful;
    bit faulty;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Hex prefix with no digit, ended by the zero byte itself.
    send_text("0x");
    push_char(8'h00);
    // Bad octal digit, then a dropped byte before the end.
    send_text("09");
    push_char(8'hFF);
    push_char(8'h00);
    // A single equals sign.
    send_text("=a");
    push_char(8'h00);
    // Mixed-case hex, octal with its first digit counted, a lone zero.
    send_text("0xfF+\t017<=0");
    push_char(8'h00);
    // A character that starts no token.
    push_char(8'hFF);
    push_char(8'h00);

    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);

    while (chars_sent < CharTarget) begin
      calm <= (exprs_sent >= 15 && exprs_sent < 30);
      if (exprs_sent % 20 == 19) begin
        s_tvalid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
      end
      build_expr(useful, faulty);
      foreach (text_q[i]) push_char(text_q[i]);
      chars_sent += useful;
      exprs_sent++;
      if (faulty) faulty_exprs++;
    end
    s_tvalid <= 1'b0;
    calm <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Sent %0d characters in %0d random expressions (%0d with a fault)",
             total_chars, exprs_sent, faulty_exprs, " plus directed cases.");
    $display("Checked %0d tokens covering %0d of 25 kinds; %0d mismatches, %0d never arrived.",
             tokens_checked, kinds_seen, mismatches, outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/clex_pkg.sv
rtl/core/clex_step.sv
rtl/core/c_expression_lexer.sv
dv/c_expression_lexer_chk.sv
dv/tb_c_expression_lexer.sv
